>>> hdl/cch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cch_pkg
// Shared codes, stream widths and helpers for the cons cell heap.
// ----------------------------------------------------------------------------
package cch_pkg;

    localparam int DEF_CELLS        = 1024;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam int FUNC_W    = 3;
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 10;
    localparam int IO_PAY_W  = 32;
    localparam int STATUS_W  = 2;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = STATUS_W;

    localparam logic [FUNC_W-1:0] FN_CAR     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CDR     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SET_CAR = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SET_CDR = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CONS    = 3'd4;

    localparam logic [KIND_W-1:0] KIND_NULL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAIR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ATOM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_PAIR = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OOM      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RSVD     = 2'd3;

    // reserved kind code is folded onto the atom kind
    function automatic logic [KIND_W-1:0] norm_kind(input logic [KIND_W-1:0] k);
        return (k == KIND_RSVD) ? KIND_ATOM : k;
    endfunction

endpackage

>>> hdl/cons_cell_heap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cons_cell_heap_core
// Cons cell heap with a free list threaded through the cdr words.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   tuser: func[2:0]
//               tdata: target_kind, target_index, first_kind, first_payload,
//                      second_kind, second_payload
// m_axis   out  tuser: status[1:0]
//               tdata: value_kind, value_payload, zero pad to 40 bits
//
// Each item is captured with its RAM read, then modified and written back;
// one RAM round trip per item, and one item at a time is taken in.
// After reset an init sweep writes every cell while s_axis_tready is low.
// A stalled result holds the write-back; a new item is taken while the
// previous result waits in the output register.
// ----------------------------------------------------------------------------
module cons_cell_heap_core #(
    parameter int CELLS        = cch_pkg::DEF_CELLS,
    parameter int PAYLOAD_BITS = cch_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // func
    input  logic [cch_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // target_kind, target_index, first_kind, first_payload, second_kind, second_payload
    input  logic [cch_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status
    output logic [cch_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    // value_kind, value_payload, pad
    output logic [cch_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import cch_pkg::*;

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int WW = PAYLOAD_BITS + KIND_W;

    logic          car_we;
    logic          cdr_we;
    logic [AW-1:0] waddr;
    logic [WW-1:0] car_wdata;
    logic [WW-1:0] cdr_wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [WW-1:0] car_rdata;
    logic [WW-1:0] cdr_rdata;

    cch_ctrl #(
        .CELLS        (CELLS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_car_we      (car_we),
        .o_cdr_we      (cdr_we),
        .o_waddr       (waddr),
        .o_car_wdata   (car_wdata),
        .o_cdr_wdata   (cdr_wdata),
        .o_re          (re),
        .o_raddr       (raddr),
        .i_car_rdata   (car_rdata),
        .i_cdr_rdata   (cdr_rdata)
    );

    cch_ram #(
        .DEPTH (CELLS),
        .WIDTH (WW),
        .AW    (AW)
    ) u_car_ram (
        .i_clk   (i_clk),
        .i_we    (car_we),
        .i_waddr (waddr),
        .i_wdata (car_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (car_rdata)
    );

    cch_ram #(
        .DEPTH (CELLS),
        .WIDTH (WW),
        .AW    (AW)
    ) u_cdr_ram (
        .i_clk   (i_clk),
        .i_we    (cdr_we),
        .i_waddr (waddr),
        .i_wdata (cdr_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (cdr_rdata)
    );

endmodule

>>> hdl/cch_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cch_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cch_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 34,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/cch_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cch_ctrl
// Sequencer: post-reset init sweep, item capture, RAM read-modify-write,
// free list head and output register.
// ----------------------------------------------------------------------------
module cch_ctrl #(
    parameter int CELLS        = 1024,
    parameter int PAYLOAD_BITS = 32,
    parameter int AW           = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [cch_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [cch_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [cch_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic [cch_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output logic                           o_car_we,
    output logic                           o_cdr_we,
    output logic [AW-1:0]                  o_waddr,
    output logic [PAYLOAD_BITS+1:0]        o_car_wdata,
    output logic [PAYLOAD_BITS+1:0]        o_cdr_wdata,
    output logic                           o_re,
    output logic [AW-1:0]                  o_raddr,
    input  logic [PAYLOAD_BITS+1:0]        i_car_rdata,
    input  logic [PAYLOAD_BITS+1:0]        i_cdr_rdata
);
    import cch_pkg::*;

    localparam int PB = PAYLOAD_BITS;
    localparam int WW = PAYLOAD_BITS + KIND_W;
    localparam logic [31:0] CELLS_U   = 32'(CELLS);
    localparam logic [63:0] CELLS_U64 = 64'(CELLS);
    localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_clr_idx;
    logic [AW-1:0]         r_head;
    logic [FUNC_W-1:0]     r_func;
    logic [KIND_W-1:0]     r_tkind;
    logic [INDEX_W-1:0]    r_tidx;
    logic [KIND_W-1:0]     r_k1;
    logic [PB-1:0]         r_p1;
    logic [KIND_W-1:0]     r_k2;
    logic [PB-1:0]         r_p2;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [KIND_W-1:0]     r_out_kind;
    logic [IO_PAY_W-1:0]   r_out_pay;

    logic [STATUS_W-1:0]   n_status;
    logic [KIND_W-1:0]     n_kind;
    logic [IO_PAY_W-1:0]   n_pay;
    logic [AW-1:0]         n_head;

    logic [FUNC_W-1:0]     in_func;
    logic [KIND_W-1:0]     in_tkind;
    logic [INDEX_W-1:0]    in_tidx;
    logic [KIND_W-1:0]     in_k1;
    logic [IO_PAY_W-1:0]   in_p1;
    logic [KIND_W-1:0]     in_k2;
    logic [IO_PAY_W-1:0]   in_p2;

    logic                  accept;
    logic                  exec_go;
    logic                  target_ok;
    logic                  cons_ok;
    logic [KIND_W-1:0]     car_kind;
    logic [PB-1:0]         car_pay;
    logic [KIND_W-1:0]     cdr_kind;
    logic [PB-1:0]         cdr_pay;
    logic [AW:0]           clr_next;

    assign in_func  = s_axis_tuser;
    assign in_tkind = s_axis_tdata[1:0];
    assign in_tidx  = s_axis_tdata[11:2];
    assign in_k1    = s_axis_tdata[13:12];
    assign in_p1    = s_axis_tdata[45:14];
    assign in_k2    = s_axis_tdata[47:46];
    assign in_p2    = s_axis_tdata[79:48];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign exec_go       = (r_state == ST_EXEC) && (!r_out_valid || m_axis_tready);

    assign o_re    = accept;
    assign o_raddr = (in_func == FN_CONS) ? r_head : AW'(in_tidx);

    assign car_kind = i_car_rdata[WW-1 -: KIND_W];
    assign car_pay  = i_car_rdata[PB-1:0];
    assign cdr_kind = i_cdr_rdata[WW-1 -: KIND_W];
    assign cdr_pay  = i_cdr_rdata[PB-1:0];

    assign target_ok = (r_tkind == KIND_PAIR) && (32'(r_tidx) < CELLS_U);
    assign cons_ok   = (cdr_kind == KIND_PAIR) && (64'(cdr_pay) < CELLS_U64);
    assign clr_next  = {1'b0, r_clr_idx} + (AW+1)'(1);

    always_comb begin
        o_car_we    = 1'b0;
        o_cdr_we    = 1'b0;
        o_waddr     = AW'(r_tidx);
        o_car_wdata = {r_k1, r_p1};
        o_cdr_wdata = (r_func == FN_CONS) ? {r_k2, r_p2} : {r_k1, r_p1};
        n_status    = STAT_OK;
        n_kind      = KIND_NULL;
        n_pay       = '0;
        n_head      = r_head;
        case (r_state)
            ST_CLEAR: begin
                o_car_we    = 1'b1;
                o_cdr_we    = 1'b1;
                o_waddr     = r_clr_idx;
                o_car_wdata = '0;
                o_cdr_wdata = (r_clr_idx == LAST_IDX) ? '0 : {KIND_PAIR, PB'(clr_next)};
            end
            ST_EXEC: begin
                case (r_func)
                    FN_CAR, FN_CDR, FN_SET_CAR, FN_SET_CDR: begin
                        if (!target_ok) begin
                            n_status = STAT_NOT_PAIR;
                        end else if (r_func == FN_CAR) begin
                            n_kind = car_kind;
                            n_pay  = 32'(car_pay);
                        end else if (r_func == FN_CDR) begin
                            n_kind = cdr_kind;
                            n_pay  = 32'(cdr_pay);
                        end else if (r_func == FN_SET_CAR) begin
                            o_car_we = exec_go;
                        end else begin
                            o_cdr_we = exec_go;
                        end
                    end
                    FN_CONS: begin
                        o_waddr = r_head;
                        if (cons_ok) begin
                            o_car_we = exec_go;
                            o_cdr_we = exec_go;
                            n_kind   = KIND_PAIR;
                            n_pay    = 32'(r_head);
                            n_head   = AW'(cdr_pay);
                        end else begin
                            n_status = STAT_OOM;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= AW'(clr_next);
                    if (r_clr_idx == LAST_IDX) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_func  <= in_func;
                        r_tkind <= norm_kind(in_tkind);
                        r_tidx  <= in_tidx;
                        r_k1    <= norm_kind(in_k1);
                        r_p1    <= PB'(in_p1);
                        r_k2    <= norm_kind(in_k2);
                        r_p2    <= PB'(in_p2);
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec_go) begin
                        r_out_status <= n_status;
                        r_out_kind   <= n_kind;
                        r_out_pay    <= n_pay;
                        r_head       <= n_head;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {(M_TDATA_W - KIND_W - IO_PAY_W)'(0), r_out_pay, r_out_kind};

endmodule

>>> hdl/cch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cch_checker
// Port-level checks for the cons cell heap, bound to the top level.
// ----------------------------------------------------------------------------
module cch_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [cch_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    input logic [cch_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import cch_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (m_axis_tdata == '0))
        else $error("error result carries a value");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != STAT_RSVD))
        else $error("reserved status code");

endmodule

bind cons_cell_heap_core cch_checker u_cch_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);

>>> test/cons_cell_heap_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cons_cell_heap_core_test
// Self-checking bench for the cons cell heap. Operations go in over the input
// stream and a shadow heap with its own free list predicts every reply, which
// is then checked in order on the output stream. A directed pass covers the
// corner cases: reset contents, non-pair targets, the reserved kind, unknown
// functions, and a broken and repaired free list. Random list building follows,
// with free-list skips that run the heap dry, while both sides stall at random.
// ----------------------------------------------------------------------------
module cons_cell_heap_core_test;
    import cch_pkg::*;

    localparam int CELLS    = DEF_CELLS;
    localparam int RAND_OPS = 1200;
    localparam int CHUNKS   = 6;
    localparam int WATCHDOG = 6000;
    localparam int FN_TOP   = (1 << FUNC_W) - 1;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [KIND_W-1:0]   tkind;
        logic [INDEX_W-1:0]  tidx;
        logic [KIND_W-1:0]   k1;
        logic [IO_PAY_W-1:0] p1;
        logic [KIND_W-1:0]   k2;
        logic [IO_PAY_W-1:0] p2;
    } heap_op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   kind;
        logic [IO_PAY_W-1:0] payload;
    } heap_reply_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // func
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    // target_kind, target_index, first_kind, first_payload, second_kind, second_payload
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // status
    logic [M_TUSER_W-1:0] m_axis_tuser;
    // value_kind, value_payload, pad
    logic [M_TDATA_W-1:0] m_axis_tdata;

    heap_op_t    op_q[$];
    heap_reply_t reply_q[$];
    heap_op_t    cur_op;

    logic [KIND_W-1:0]   car_kind_sh [CELLS];
    logic [IO_PAY_W-1:0] car_pay_sh  [CELLS];
    logic [KIND_W-1:0]   cdr_kind_sh [CELLS];
    logic [IO_PAY_W-1:0] cdr_pay_sh  [CELLS];
    int unsigned         free_head_sh;

    // stimulus-side view of the free list and of the cells handed out
    int unsigned gen_head;
    int unsigned gen_link;
    int unsigned alloc_q[$];

    int errors      = 0;
    bit calm        = 1'b0;
    int send_gap    = 0;
    int stall_left  = 0;
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    cons_cell_heap_core #(
        .CELLS        (CELLS),
        .PAYLOAD_BITS (DEF_PAYLOAD_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    // reserved kind reads as atom
    function automatic logic [KIND_W-1:0] fold_kind(input logic [KIND_W-1:0] k);
        return {k[1], k[0] & ~k[1]};
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void heap_clear();
        for (int i = 0; i < CELLS; i++) begin
            car_kind_sh[i] = KIND_NULL;
            car_pay_sh[i]  = '0;
            cdr_kind_sh[i] = (i < CELLS - 1) ? KIND_PAIR : KIND_NULL;
            cdr_pay_sh[i]  = (i < CELLS - 1) ? IO_PAY_W'(i + 1) : '0;
        end
        free_head_sh = 0;
    endfunction

    // apply one accepted operation to the shadow heap, queue its reply
    function automatic void heap_apply(input heap_op_t op);
        heap_reply_t r;
        logic [KIND_W-1:0] tk;
        int unsigned h;
        r.status  = STAT_OK;
        r.kind    = KIND_NULL;
        r.payload = '0;
        tk = fold_kind(op.tkind);
        h  = free_head_sh;
        case (op.func)
            FN_CAR, FN_CDR, FN_SET_CAR, FN_SET_CDR: begin
                if (tk != KIND_PAIR || int'(op.tidx) >= CELLS) begin
                    r.status = STAT_NOT_PAIR;
                end else begin
                    case (op.func)
                        FN_CAR: begin
                            r.kind    = car_kind_sh[op.tidx];
                            r.payload = car_pay_sh[op.tidx];
                        end
                        FN_CDR: begin
                            r.kind    = cdr_kind_sh[op.tidx];
                            r.payload = cdr_pay_sh[op.tidx];
                        end
                        FN_SET_CAR: begin
                            car_kind_sh[op.tidx] = fold_kind(op.k1);
                            car_pay_sh[op.tidx]  = op.p1;
                        end
                        default: begin
                            cdr_kind_sh[op.tidx] = fold_kind(op.k1);
                            cdr_pay_sh[op.tidx]  = op.p1;
                        end
                    endcase
                end
            end
            FN_CONS: begin
                if (h >= CELLS || cdr_kind_sh[h] != KIND_PAIR || cdr_pay_sh[h] >= CELLS) begin
                    r.status = STAT_OOM;
                end else begin
                    free_head_sh   = cdr_pay_sh[h];
                    car_kind_sh[h] = fold_kind(op.k1);
                    car_pay_sh[h]  = op.p1;
                    cdr_kind_sh[h] = fold_kind(op.k2);
                    cdr_pay_sh[h]  = op.p2;
                    r.kind         = KIND_PAIR;
                    r.payload      = IO_PAY_W'(h);
                end
            end
            default: begin
            end
        endcase
        reply_q.push_back(r);
    endfunction

    task automatic add_op(input logic [FUNC_W-1:0] func, input logic [KIND_W-1:0] tkind,
                          input int unsigned tidx, input logic [KIND_W-1:0] k1,
                          input logic [IO_PAY_W-1:0] p1, input logic [KIND_W-1:0] k2,
                          input logic [IO_PAY_W-1:0] p2);
        heap_op_t op;
        op.func  = func;
        op.tkind = tkind;
        op.tidx  = INDEX_W'(tidx);
        op.k1    = k1;
        op.p1    = p1;
        op.k2    = k2;
        op.p2    = p2;
        if (func == FN_CONS && gen_link < CELLS) begin
            alloc_q.push_back(gen_head);
            gen_head = gen_link;
            gen_link = gen_head + 1;
        end
        if (func == FN_SET_CDR && fold_kind(tkind) == KIND_PAIR && tidx == gen_head) begin
            gen_link = (fold_kind(k1) == KIND_PAIR && p1 < CELLS) ? p1 : CELLS;
        end
        op_q.push_back(op);
    endtask

    task automatic wait_idle(input bit drain_replies);
        while (op_q.size() > 0 || s_axis_tvalid || (drain_replies && reply_q.size() > 0)) begin
            @(negedge i_clk);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (errors < 40) begin
            $display("%0t: mismatch on %s: want %0h got %0h", $time, what, want, got);
        end
        errors++;
    endtask

    // input side
    always @(posedge i_clk) begin : drive
        bit fire;
        fire = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (fire) begin
                heap_apply(cur_op);
                send_gap = idle_len();
            end
            if (!s_axis_tvalid || fire) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (op_q.size() > 0) begin
                    cur_op = op_q.pop_front();
                    s_axis_tuser  <= cur_op.func;
                    s_axis_tdata  <= {cur_op.p2, cur_op.k2, cur_op.p1, cur_op.k1,
                                      cur_op.tidx, cur_op.tkind};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin : monitor
        heap_reply_t want;
        int next_stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            next_stall = stall_left;
            if (m_axis_tvalid && m_axis_tready) begin
                if (reply_q.size() == 0) begin
                    flag_mismatch("reply with none pending", '0,
                                  64'({m_axis_tuser, m_axis_tdata}));
                end else begin
                    want = reply_q.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        flag_mismatch("status", 64'(want.status), 64'(m_axis_tuser));
                    end
                    if (m_axis_tdata[KIND_W-1:0] !== want.kind) begin
                        flag_mismatch("value_kind", 64'(want.kind),
                                      64'(m_axis_tdata[KIND_W-1:0]));
                    end
                    if (m_axis_tdata[KIND_W +: IO_PAY_W] !== want.payload) begin
                        flag_mismatch("value_payload", 64'(want.payload),
                                      64'(m_axis_tdata[KIND_W +: IO_PAY_W]));
                    end
                end
                next_stall = idle_len();
            end
            if (next_stall > 0) begin
                m_axis_tready <= 1'b0;
                stall_left = next_stall - 1;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int r;
        int unsigned live;
        int unsigned idx;
        int unsigned skip;
        logic [KIND_W-1:0] kb;
        logic [IO_PAY_W-1:0] pb;
        heap_clear();
        gen_head = 0;
        gen_link = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset contents and non-pair targets
        add_op(FN_CAR, KIND_PAIR, 0, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_CDR, KIND_PAIR, 0, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_CDR, KIND_PAIR, CELLS - 1, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_CAR, KIND_NULL, 5, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_CDR, KIND_ATOM, 0, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_SET_CAR, KIND_RSVD, 1, KIND_ATOM, 32'hDEAD_BEEF, KIND_NULL, '0);
        add_op(FN_SET_CDR, KIND_NULL, 1, KIND_NULL, '0, KIND_NULL, '0);
        // allocation, reserved kind stored, extreme payloads
        add_op(FN_CONS, KIND_NULL, 0, KIND_RSVD, 32'hFFFF_FFFF, KIND_NULL, '0);
        add_op(FN_CAR, KIND_PAIR, 0, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_CDR, KIND_PAIR, 0, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_CONS, KIND_RSVD, CELLS - 1, KIND_PAIR, '0, KIND_RSVD, 32'hFFFF_FFFF);
        add_op(FN_SET_CAR, KIND_PAIR, 1, KIND_RSVD, 32'h5555_AAAA, KIND_ATOM, 32'hFFFF_FFFF);
        add_op(FN_SET_CDR, KIND_PAIR, 1, KIND_PAIR, 32'hAAAA_5555, KIND_NULL, '0);
        add_op(FN_CAR, KIND_PAIR, 1, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_CDR, KIND_PAIR, 1, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_SET_CAR, KIND_PAIR, CELLS - 1, KIND_ATOM, 32'hFFFF_FFFF, KIND_NULL, '0);
        add_op(FN_CAR, KIND_PAIR, CELLS - 1, KIND_NULL, '0, KIND_NULL, '0);
        // unknown functions
        for (int f = FN_CONS + 1; f <= FN_TOP; f++) begin
            add_op(FUNC_W'(f), KIND_PAIR, 2, KIND_ATOM, $urandom(), KIND_ATOM, $urandom());
        end
        // free list broken at the head: out-of-range link, then null, then repaired
        add_op(FN_SET_CDR, KIND_PAIR, gen_head, KIND_PAIR, 32'hFFFF_FC00, KIND_NULL, '0);
        add_op(FN_CONS, KIND_NULL, 0, KIND_ATOM, 32'h1, KIND_NULL, '0);
        add_op(FN_SET_CDR, KIND_PAIR, gen_head, KIND_NULL, '0, KIND_NULL, '0);
        add_op(FN_CONS, KIND_NULL, 0, KIND_ATOM, 32'h2, KIND_NULL, '0);
        add_op(FN_SET_CDR, KIND_PAIR, gen_head, KIND_PAIR, gen_head + 1, KIND_NULL, '0);
        add_op(FN_CONS, KIND_NULL, 0, KIND_ATOM, 32'h3, KIND_PAIR, 32'h1);
        wait_idle(1'b1);

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            calm = (chunk == 3);
            for (int n = 0; n < RAND_OPS / CHUNKS; n++) begin
                r    = $urandom_range(0, 99);
                live = alloc_q[$urandom_range(0, alloc_q.size() - 1)];
                idx  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CELLS - 1) : live;
                kb   = KIND_W'($urandom_range(0, 3));
                pb   = $urandom();
                if (r < 34 && !(r >= 30 && gen_head < CELLS - 1)) begin
                    // list building: the cdr often links back to a live cell
                    if ($urandom_range(0, 1) == 1) begin
                        kb = KIND_PAIR;
                        pb = live;
                    end
                    add_op(FN_CONS, KIND_W'($urandom_range(0, 3)),
                           $urandom_range(0, CELLS - 1),
                           KIND_W'($urandom_range(0, 3)), $urandom(), kb, pb);
                end else if (r < 34) begin
                    // skip the free list forward
                    skip = gen_head + $urandom_range(1, 60);
                    add_op(FN_SET_CDR, KIND_PAIR, gen_head, KIND_PAIR,
                           (skip < CELLS) ? skip : CELLS - 1, KIND_NULL, '0);
                end else if (r < 49) begin
                    add_op(FN_CAR, KIND_PAIR, idx, kb, pb, kb, pb);
                end else if (r < 64) begin
                    add_op(FN_CDR, KIND_PAIR, idx, kb, pb, kb, pb);
                end else if (r < 76) begin
                    add_op(FN_SET_CAR, KIND_PAIR, idx, kb, pb,
                           KIND_W'($urandom_range(0, 3)), $urandom());
                end else if (r < 86) begin
                    if ($urandom_range(0, 1) == 1) begin
                        kb = KIND_PAIR;
                        pb = alloc_q[$urandom_range(0, alloc_q.size() - 1)];
                    end
                    add_op(FN_SET_CDR, KIND_PAIR, live, kb, pb,
                           KIND_W'($urandom_range(0, 3)), $urandom());
                end else if (r < 94) begin
                    case ($urandom_range(0, 2))
                        0: kb = KIND_NULL;
                        1: kb = KIND_ATOM;
                        default: kb = KIND_RSVD;
                    endcase
                    add_op(FUNC_W'($urandom_range(FN_CAR, FN_SET_CDR)), kb,
                           $urandom_range(0, CELLS - 1),
                           KIND_W'($urandom_range(0, 3)), $urandom(),
                           KIND_W'($urandom_range(0, 3)), $urandom());
                end else begin
                    add_op(FUNC_W'($urandom_range(FN_CONS + 1, FN_TOP)),
                           KIND_W'($urandom_range(0, 3)),
                           $urandom_range(0, CELLS - 1), KIND_W'($urandom_range(0, 3)),
                           $urandom(), KIND_W'($urandom_range(0, 3)), $urandom());
                end
            end
            wait_idle(chunk == 2);
        end

        wait_idle(1'b1);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/cch_pkg.sv
hdl/cch_ram.sv
hdl/cch_ctrl.sv
hdl/cons_cell_heap_core.sv
hdl/cch_checker.sv
test/cons_cell_heap_core_test.sv
